// ===== sv/fexp_pkg.sv =====
// Shared types, constants and IEEE-754 single-precision arithmetic for the exp unit.
// Used by the stage modules and the top level; depends on nothing else.
package fexp_pkg;

  localparam int unsigned STAGES = 20;

  localparam logic [31:0] LOG2E   = 32'h3FB8_AA3B;
  localparam logic [31:0] LN2_HI  = 32'h3F31_7200;
  localparam logic [31:0] LN2_LO  = 32'h35BF_BE8E;
  localparam logic [31:0] HALF    = 32'h3F00_0000;
  localparam logic [31:0] QNAN    = 32'h7FC0_0000;
  localparam logic [31:0] POS_INF = 32'h7F80_0000;
  localparam logic [30:0] LIM_MAG = 31'h42B0_0000;  // |88.0|

  localparam logic [31:0] POLY [0:6] = '{
    32'h3AB6_ECC1, 32'h3C09_37D6, 32'h3D2A_AA0E, 32'h3E2A_AA02,
    32'h3F00_0000, 32'h3F80_0000, 32'h3F80_0000
  };

  // Sideband that travels with each item through the pipe
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] nf;
    logic [31:0] r;
    logic [7:0]  scale;
    logic        spec;
    logic [31:0] spec_val;
  } sband_t;

  function automatic logic [5:0] clz48(input logic [47:0] m);
    logic [5:0] lz;
    lz = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (m[i]) lz = 6'(47 - i);
    end
    return lz;
  endfunction

  // Normalize and round to nearest even. Value is m * 2^(e - 174).
  function automatic logic [31:0] round_pack(input logic s, input logic signed [10:0] e,
                                             input logic [47:0] m);
    logic [5:0]         lz;
    logic signed [10:0] er;
    logic [47:0]        pn;
    logic [47:0]        sm;
    logic [5:0]         sh;
    logic               stk;
    logic               g;
    logic [24:0]        mr;
    logic [30:0]        mag;
    lz  = clz48(m);
    er  = e - $signed({5'b0, lz});
    pn  = m << lz;
    stk = 1'b0;
    sm  = pn;
    if (er < 11'sd1) begin
      if (er <= -11'sd47) sh = 6'd48;
      else sh = 6'(11'sd1 - er);
      stk = |(pn & ((48'd1 << sh) - 48'd1));
      sm  = pn >> sh;
    end
    g   = sm[23];
    stk = stk | (|sm[22:0]);
    mr  = {1'b0, sm[47:24]} + {24'b0, g & (stk | sm[24])};
    if (er < 11'sd1) mag = {6'b0, mr};
    else mag = {8'(er - 11'sd1), 23'b0} + {6'b0, mr};
    if (m == 48'd0) return {s, 31'b0};
    if (er >= 11'sd255) return {s, POS_INF[30:0]};
    return {s, mag};
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic [23:0]        ma;
    logic [23:0]        mb;
    logic [7:0]         ea;
    logic [7:0]         eb;
    logic [47:0]        p;
    logic signed [10:0] e;
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};
    p  = ma * mb;
    e  = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126;
    return round_pack(a[31] ^ b[31], e, p);
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  eg;
    logic [7:0]  es;
    logic [7:0]  d;
    logic [26:0] mg;
    logic [26:0] ms;
    logic [26:0] msh;
    logic        stk;
    logic [27:0] sum;
    logic        s;
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    eg  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d   = eg - es;
    mg  = {(big[30:23] != 8'd0), big[22:0], 3'b0};
    ms  = {(sml[30:23] != 8'd0), sml[22:0], 3'b0};
    if (d >= 8'd27) begin
      msh = {26'b0, |ms};
    end else begin
      stk = |(ms & ((27'd1 << d) - 27'd1));
      msh = ms >> d;
      msh[0] = msh[0] | stk;
    end
    if (big[31] == sml[31]) sum = {1'b0, mg} + {1'b0, msh};
    else sum = {1'b0, mg} - {1'b0, msh};
    s = big[31];
    if (sum == 28'd0) s = (big[31] == sml[31]) ? big[31] : 1'b0;
    return round_pack(s, $signed({3'b0, eg}) + 11'sd1, {sum, 20'b0});
  endfunction

endpackage

// ===== sv/fexp_mul_stage.sv =====
// One pipeline stage: rounded single-precision multiply into a register.
// Depends on fexp_pkg.
module fexp_mul_stage (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] res_r
);

  logic [31:0] res_nxt;

  assign res_nxt = fexp_pkg::fmul(a, b);

  // Product register, held on stall
  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

endmodule

// ===== sv/fexp_add_stage.sv =====
// One pipeline stage: rounded single-precision add into a register.
// Depends on fexp_pkg; subtract by flipping the sign of b at the caller.
module fexp_add_stage (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] res_r
);

  logic [31:0] res_nxt;

  assign res_nxt = fexp_pkg::fadd(a, b);

  // Sum register, held on stall
  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

endmodule

// ===== sv/float_exponential_top.sv =====
// Single-precision e^x: range limits, Cody-Waite reduction, Horner polynomial, scale.
// One item per cycle sustained unless the output stalls.
// One float multiply, add or truncation per stage sets the depth; the whole pipe
// advances together and holds when the output is valid but not taken.
// Reset (rst_n low, synchronous) clears all stage valid bits; data registers are not reset.
// Depends on fexp_pkg, fexp_mul_stage, fexp_add_stage.
module float_exponential_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] x_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] exp_bits
);

  localparam int unsigned NS = fexp_pkg::STAGES;

  logic                 adv;
  logic [NS:1]          vld_r;
  fexp_pkg::sband_t     sb_r   [1:NS];
  fexp_pkg::sband_t     sb_nxt [1:NS];
  wire  [31:0]          res    [1:NS];
  logic [31:0]          opa    [1:NS];
  logic [31:0]          opb    [1:NS];

  logic                 is_nan;
  logic                 too_big;
  logic                 too_small;
  logic [31:0]          t2;
  logic [7:0]           te;
  logic [7:0]           tsh;
  logic [7:0]           tmag;
  logic [31:0]          nf_c;

  // Whole pipe moves unless the output is stalled
  assign adv        = !vld_r[NS] || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[NS];
  assign out_tdata  = sb_r[NS].spec ? sb_r[NS].spec_val : res[NS];

  // Input classification
  assign is_nan    = (in_tdata[30:23] == 8'hFF) && (in_tdata[22:0] != 23'd0);
  assign too_big   = !in_tdata[31] && (in_tdata[30:0] > fexp_pkg::LIM_MAG);
  assign too_small = in_tdata[31] && (in_tdata[30:0] > fexp_pkg::LIM_MAG);

  // Truncate t toward zero: n as integer and as float
  assign t2 = res[2];
  assign te = t2[30:23];
  always_comb begin
    tsh  = (te > 8'd150) ? 8'd0 : 8'd150 - te;
    tmag = 8'({1'b1, t2[22:0]} >> tsh);
    nf_c = {t2[31:23], t2[22:0] & ~((23'd1 << tsh) - 23'd1)};
    if (te < 8'd127) begin
      tmag = 8'd0;
      nf_c = 32'd0;
    end
  end

  // Sideband next values
  always_comb begin
    sb_nxt[1].x        = in_tdata;
    sb_nxt[1].nf       = 32'd0;
    sb_nxt[1].r        = 32'd0;
    sb_nxt[1].scale    = 8'd0;
    sb_nxt[1].spec     = is_nan || too_big || too_small;
    sb_nxt[1].spec_val = is_nan ? fexp_pkg::QNAN : (too_big ? fexp_pkg::POS_INF : 32'd0);
    for (int k = 2; k <= NS; k++) sb_nxt[k] = sb_r[k-1];
    sb_nxt[3].nf    = nf_c;
    sb_nxt[3].scale = t2[31] ? (8'd127 - tmag) : (8'd127 + tmag);
    sb_nxt[6].r     = res[5];
    sb_nxt[8].r     = res[7];
  end

  // Operand routing per stage
  always_comb begin
    for (int k = 1; k <= NS; k++) begin
      opa[k] = res[k-1 > 0 ? k-1 : 1];
      opb[k] = 32'd0;
    end
    opa[1] = in_tdata;
    opb[1] = fexp_pkg::LOG2E;
    opa[2] = res[1];
    opb[2] = {res[1][31], fexp_pkg::HALF[30:0]};
    opa[4] = sb_r[3].nf;
    opb[4] = fexp_pkg::LN2_HI;
    opa[5] = sb_r[4].x;
    opb[5] = {~res[4][31], res[4][30:0]};
    opa[6] = sb_r[5].nf;
    opb[6] = fexp_pkg::LN2_LO;
    opa[7] = sb_r[6].r;
    opb[7] = {~res[6][31], res[6][30:0]};
    for (int k = 8; k < NS; k++) begin
      if (k % 2 == 0) begin
        opa[k] = (k == 8) ? fexp_pkg::POLY[0] : res[k-1];
        opb[k] = (k == 8) ? res[7] : sb_r[k-1].r;
      end else begin
        opa[k] = res[k-1];
        opb[k] = fexp_pkg::POLY[(k-7)/2];
      end
    end
    opa[NS] = res[NS-1];
    opb[NS] = {1'b0, sb_r[NS-1].scale, 23'b0};
  end

  // Arithmetic stages
  genvar g;
  generate
    for (g = 1; g <= NS; g++) begin : g_stg
      if (g == 3) begin : g_trunc
        assign res[g] = sb_r[3].nf;
      end else if (g == 1 || (g >= 4 && g % 2 == 0)) begin : g_mul
        fexp_mul_stage u_mul (
          .clk   (clk),
          .en    (adv),
          .a     (opa[g]),
          .b     (opb[g]),
          .res_r (res[g])
        );
      end else begin : g_add
        fexp_add_stage u_add (
          .clk   (clk),
          .en    (adv),
          .a     (opa[g]),
          .b     (opb[g]),
          .res_r (res[g])
        );
      end
    end
  endgenerate

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-1:1], in_tvalid};
    end
  end

  // Sideband registers
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k <= NS; k++) sb_r[k] <= sb_nxt[k];
    end
  end

`ifndef SYNTHESIS
  // A stalled output must stop input transfers
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while output stalled");

  // An accepted input lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[1])
    else $error("accepted item lost at pipe entry");

  // e^x on the polynomial path is never negative
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !sb_r[NS].spec) |-> !out_tdata[31])
    else $error("negative exp result");

  // Special results are one of the three fixed codes
  a_spec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && sb_r[NS].spec) |-> (out_tdata == fexp_pkg::QNAN ||
      out_tdata == fexp_pkg::POS_INF || out_tdata == 32'd0))
    else $error("bad special result");
`endif

endmodule

// ===== tb/float_exponential_checker.sv =====
// Checker for float_exponential_top: watches both stream channels, predicts e^x
// in bit-exact single precision, and compares each output transfer in order.
// Depends only on the port list of float_exponential_top.
module float_exponential_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] x_bits
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] exp_bits
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] C_LOG2E  = 32'h3FB8_AA3B;
  localparam logic [31:0] C_LN2_HI = 32'h3F31_7200;
  localparam logic [31:0] C_LN2_LO = 32'h35BF_BE8E;
  localparam logic [31:0] C_HALF   = 32'h3F00_0000;
  localparam logic [31:0] C_QNAN   = 32'h7FC0_0000;
  localparam logic [31:0] C_INF    = 32'h7F80_0000;
  localparam logic [30:0] C_LIMIT  = 31'h42B0_0000;  // 88.0

  localparam logic [31:0] HORNER [0:6] = '{
    32'h3AB6_ECC1, 32'h3C09_37D6, 32'h3D2A_AA0E, 32'h3E2A_AA02,
    32'h3F00_0000, 32'h3F80_0000, 32'h3F80_0000
  };

  logic [31:0] exp_expected [$];

  // Round m * 2^e to single precision, nearest even
  function automatic logic [31:0] sp_round(input logic s, input int e, input logic [63:0] m);
    int          msb;
    int          sh;
    int          ex;
    int          bexp;
    logic [63:0] q;
    logic        g;
    logic        st;
    if (m == 64'd0) return {s, 31'b0};
    msb = 0;
    for (int i = 0; i < 64; i++) if (m[i]) msb = i;
    sh = msb - 23;
    if (-149 - e > sh) sh = -149 - e;
    if (sh > 64) begin
      q = 64'd0;
    end else if (sh > 0) begin
      q  = m >> sh;
      g  = m[sh-1];
      st = (m & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
      q  = q + {63'd0, g & (st | q[0])};
    end else begin
      q = m << (-sh);
    end
    ex = e + sh;
    if (q[24]) begin
      q  = q >> 1;
      ex = ex + 1;
    end
    if (!q[23]) return {s, 8'd0, q[22:0]};
    bexp = ex + 150;
    if (bexp >= 255) return {s, C_INF[30:0]};
    return {s, bexp[7:0], q[22:0]};
  endfunction

  // Split a finite pattern into sign, integer mantissa and exponent of its lsb
  function automatic void sp_split(input logic [31:0] a, output logic s, output int e,
                                   output logic [63:0] m);
    s = a[31];
    if (a[30:23] == 8'd0) begin
      m = {41'd0, a[22:0]};
      e = -149;
    end else begin
      m = {40'd0, 1'b1, a[22:0]};
      e = int'(a[30:23]) - 150;
    end
  endfunction

  function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
    logic        sa, sb;
    int          ea, eb;
    logic [63:0] ma, mb;
    sp_split(a, sa, ea, ma);
    sp_split(b, sb, eb, mb);
    return sp_round(sa ^ sb, ea + eb, ma * mb);
  endfunction

  function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
    logic        sa, sb, sh_s, sl_s;
    int          ea, eb, eh, el, d;
    logic [63:0] ma, mb, mh, ml;
    sp_split(a, sa, ea, ma);
    sp_split(b, sb, eb, mb);
    if (ma == 64'd0 && mb == 64'd0) return {sa & sb, 31'b0};
    if (ma == 64'd0) return b;
    if (mb == 64'd0) return a;
    // order by magnitude so the difference is never negative
    if (a[30:0] >= b[30:0]) begin
      sh_s = sa; eh = ea; mh = ma; sl_s = sb; el = eb; ml = mb;
    end else begin
      sh_s = sb; eh = eb; mh = mb; sl_s = sa; el = ea; ml = ma;
    end
    d = eh - el;
    if (d > 38) begin
      // far smaller operand only matters as a sticky bit
      mh = mh << 39;
      ml = 64'd1;
      el = eh - 39;
    end else begin
      mh = mh << d;
    end
    if (sh_s == sl_s) return sp_round(sh_s, el, mh + ml);
    if (mh == ml) return 32'h0000_0000;
    return sp_round(sh_s, el, mh - ml);
  endfunction

  function automatic logic [31:0] exp_single(input logic [31:0] xb);
    logic [31:0] t, nf, r, p, scale;
    logic        st;
    int          et, n;
    logic [63:0] mt, mag;
    if (xb[30:23] == 8'hFF && xb[22:0] != 23'd0) return C_QNAN;
    if (xb[31] && xb[30:0] > C_LIMIT) return 32'h0000_0000;
    if (!xb[31] && xb[30:0] > C_LIMIT) return C_INF;
    t = sp_mul(xb, C_LOG2E);
    // negative zero counts as not below zero
    if (!t[31] || t[30:0] == 31'd0) t = sp_add(t, C_HALF);
    else t = sp_add(t, {1'b1, C_HALF[30:0]});
    // truncate toward zero
    sp_split(t, st, et, mt);
    if (et >= 0) mag = mt << et;
    else if (-et >= 64) mag = 64'd0;
    else mag = mt >> (-et);
    n  = st ? -int'(mag) : int'(mag);
    nf = sp_round(n < 0, 0, (n < 0) ? 64'(-n) : 64'(n));
    r  = sp_add(xb, sp_mul(nf, C_LN2_HI) ^ 32'h8000_0000);
    r  = sp_add(r, sp_mul(nf, C_LN2_LO) ^ 32'h8000_0000);
    p  = HORNER[0];
    for (int k = 1; k < 7; k++) p = sp_add(sp_mul(p, r), HORNER[k]);
    scale = {1'b0, 8'(n + 127), 23'd0};
    return sp_mul(p, scale);
  endfunction

  assign pending = exp_expected.size();

  // Predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) exp_expected.push_back(exp_single(in_tdata));
      if (out_tvalid && out_tready) begin
        if (exp_expected.size() == 0) begin
          $error("exp_bits: unexpected transfer, actual %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = exp_expected.pop_front();
          if (want !== out_tdata) begin
            $error("exp_bits: expected %h actual %h", want, out_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb.sv =====
// Top of the float_exponential_top testbench: clock, reset, stream stimulus with random gaps
// and back-pressure, watchdog and verdict. Depends on the DUT and float_exponential_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 800;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYC  = 60;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;    // [31:0] x_bits
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // [31:0] exp_bits
  int          fail_count;
  int          pending;
  int          idle_cyc;
  logic        no_gaps;

  logic [31:0] corner_x [0:23] = '{
    32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h0000_0001,
    32'h8000_0001, 32'h007F_FFFF, 32'h42B0_0000, 32'hC2B0_0000, 32'h42B0_0001,
    32'hC2B0_0001, 32'h7F80_0000, 32'hFF80_0000, 32'h7F80_0001, 32'hFFFF_FFFF,
    32'h7FC0_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3F00_0000, 32'hC2AF_0000,
    32'hC2AE_AC50, 32'h42AF_FFFF, 32'h3F31_7218, 32'hBF31_7218
  };

  float_exponential_top i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready, .out_tdata
  );

  float_exponential_checker i_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready, .out_tdata,
    .fail_count, .pending
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly values inside the polynomial range, the rest any pattern
  function automatic logic [31:0] rand_x();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return {1'($urandom), 31'($urandom_range(0, 32'h42B4_0000))};
    if (roll < 75) return {1'($urandom), 31'($urandom_range(32'h3000_0000, 32'h3F80_0000))};
    return $urandom();
  endfunction

  task automatic send_x(input logic [31:0] x);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= x;
    do @(posedge clk); while (!in_tready);
  endtask

  // receiver back-pressure
  initial begin
    out_tready = 1'b0;
    forever begin
      int gap;
      @(posedge clk);
      gap = gap_len();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cyc <= 0;
    end else begin
      idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("** float_exponential_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 32'd0;
    no_gaps   = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (corner_x[k]) send_x(corner_x[k]);
    for (int k = 0; k < NUM_RANDOM; k++) begin
      // stretches at full rate
      if (k % 100 == 0) no_gaps <= ($urandom_range(0, 3) == 0);
      send_x(rand_x());
    end
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_count == 0) begin
      $display("** float_exponential_top: PASSED **");
    end else begin
      $display("** float_exponential_top: FAILED **");
    end
    $finish;
  end
endmodule

// ===== float_exponential_top.f =====
sv/fexp_pkg.sv
sv/fexp_mul_stage.sv
sv/fexp_add_stage.sv
sv/float_exponential_top.sv
tb/float_exponential_checker.sv
tb/tb.sv
